/* rtl/ddn_pkg.sv */
package ddn_pkg;

   localparam int MaxCandidates = 32;
   localparam int MaxClasses    = 128;
   localparam int CandIdxW      = $clog2(MaxCandidates);
   localparam int CandCntW      = $clog2(MaxCandidates + 1);
   localparam int ClassW        = 7;
   localparam int ClassIdxW     = $clog2(MaxClasses + 1);

   localparam logic [2:0] CSR_CONF_THRESHOLD    = 3'd0;
   localparam logic [2:0] CSR_OVERLAP_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_CLASS_COUNT       = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH       = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT      = 3'd4;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        box_width;
      logic [15:0]        box_height;
      logic [15:0]        class_score;
      logic               last_class;
      logic               last_anchor;
   } req_data_type;

   typedef struct packed {
      logic [12:0]       rect_left;
      logic [12:0]       rect_top;
      logic [12:0]       rect_right;
      logic [12:0]       rect_bottom;
      logic [15:0]       det_score;
      logic [ClassW-1:0] det_class;
      logic              rect_empty;
      logic              summary_flag;
      logic              overflow_flag;
      logic              last_item;
   } rsp_data_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_NMS_START,
      CMD_DIFF,
      CMD_MINT,
      CMD_MAREA_A,
      CMD_MAREA_B,
      CMD_UNION,
      CMD_THR_LO,
      CMD_THR_HI,
      CMD_COMPARE,
      CMD_SET_KEPT,
      CMD_EMIT,
      CMD_SUMMARY
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [CandIdxW-1:0] idx_i;
      logic [CandIdxW-1:0] idx_j;
      logic                keep;
   } ddn_cmd_type;

   typedef struct packed {
      logic [CandCntW-1:0] cand_count;
      logic                kept_j;
      logic                class_eq;
      logic                overlap;
   } ddn_status_type;

endpackage

/* rtl/ddn_datapath.sv */
module ddn_datapath
   import ddn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  req_data_type   req_data,
   input  logic           csr_write_enable,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_data,
   input  ddn_cmd_type    cmd,
   output ddn_status_type status,
   output logic           rsp_valid,
   output rsp_data_type   rsp_data
);

   typedef struct packed {
      logic signed [17:0] left;
      logic signed [17:0] top;
      logic signed [17:0] right;
      logic signed [17:0] bottom;
      logic [15:0]        score;
      logic [ClassW-1:0]  cls;
   } cand_type;

   logic [15:0] conf_thr_ff, ovl_thr_ff;
   logic [7:0]  class_count_ff;
   logic [12:0] image_width_ff, image_height_ff;

   logic [15:0]          best_score_ff, best_score_in;
   logic [ClassW-1:0]    best_class_ff, best_class_in;
   logic [ClassIdxW-1:0] class_index_ff, class_index_in;
   logic                 seen_ff, seen_in;

   cand_type            cand_ff [MaxCandidates];
   cand_type            cand_in [MaxCandidates];
   logic [CandCntW-1:0] count_ff, count_in;
   logic [MaxCandidates-1:0] kept_ff, kept_in;
   logic                dropped_ff, dropped_in;
   logic [15:0]         img_score_ff, img_score_in;

   logic [17:0] dx_ff, dy_ff, wa_ff, ha_ff, wb_ff, hb_ff;
   logic [35:0] inter_ff, area_a_ff, area_b_ff;
   logic [36:0] uni_ff;
   logic [31:0] plo_ff;
   logic [36:0] phi_ff;

   logic          rsp_valid_ff;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   // argmax and candidate insertion
   logic [ClassIdxW-1:0] limit;
   logic                 take;
   logic                 anchor_end, ins_go, full, no_slot;
   logic [MaxCandidates-1:0] ge;
   logic signed [17:0]   nl, nt, nr, nb;
   cand_type             new_c;

   always_comb begin
      limit = (class_count_ff > 8'(MaxClasses)) ? ClassIdxW'(MaxClasses)
                                                : ClassIdxW'(class_count_ff);
      take = (class_index_ff < limit) &&
             (!seen_ff || req_data.class_score > best_score_ff);
      best_score_in  = take ? req_data.class_score : best_score_ff;
      best_class_in  = take ? class_index_ff[ClassW-1:0] : best_class_ff;
      seen_in        = seen_ff | take;
      class_index_in = (class_index_ff < ClassIdxW'(MaxClasses)) ?
                       class_index_ff + 1'b1 : class_index_ff;
      anchor_end = req_data.last_class | req_data.last_anchor;
      ins_go = anchor_end && seen_in && (best_score_in >= conf_thr_ff);
      nl = 18'(2 * 18'(req_data.center_x)) - $signed({2'b00, req_data.box_width});
      nr = 18'(2 * 18'(req_data.center_x)) + $signed({2'b00, req_data.box_width});
      nt = 18'(2 * 18'(req_data.center_y)) - $signed({2'b00, req_data.box_height});
      nb = 18'(2 * 18'(req_data.center_y)) + $signed({2'b00, req_data.box_height});
      new_c = '{left: nl, top: nt, right: nr, bottom: nb,
                score: best_score_in, cls: best_class_in};
      for (int k = 0; k < MaxCandidates; k++) begin
         ge[k] = (CandCntW'(k) < count_ff) && (cand_ff[k].score >= best_score_in);
      end
      full    = (count_ff == CandCntW'(MaxCandidates));
      no_slot = full && ge[MaxCandidates-1];
      for (int k = 0; k < MaxCandidates; k++) begin
         if (ge[k]) begin
            cand_in[k] = cand_ff[k];
         end else if (k == 0) begin
            cand_in[k] = new_c;
         end else if (ge[k-1]) begin
            cand_in[k] = new_c;
         end else begin
            cand_in[k] = cand_ff[k-1];
         end
      end
   end

   // pair geometry for the overlap test, a is the earlier entry j
   cand_type ca, cb, ce;
   logic signed [17:0] x1, y1, x2, y2;
   logic [52:0] lhs, rhs;

   always_comb begin
      ca = cand_ff[cmd.idx_j];
      cb = cand_ff[cmd.idx_i];
      ce = cand_ff[cmd.idx_i];
      x1 = (ca.left > cb.left) ? ca.left : cb.left;
      y1 = (ca.top > cb.top) ? ca.top : cb.top;
      x2 = (ca.right < cb.right) ? ca.right : cb.right;
      y2 = (ca.bottom < cb.bottom) ? ca.bottom : cb.bottom;
      lhs = {1'b0, inter_ff, 16'd0};
      rhs = {phi_ff, 16'd0} + 53'(plo_ff);
   end

   // rectangle of the entry being emitted
   logic signed [19:0] fl, ft, cr, cbt, wlim, hlim;
   logic [12:0] ol, ot, orr, ob;

   always_comb begin
      fl  = 20'(ce.left) >>> 5;
      ft  = 20'(ce.top) >>> 5;
      cr  = (20'(ce.right) + 20'sd31) >>> 5;
      cbt = (20'(ce.bottom) + 20'sd31) >>> 5;
      wlim = $signed({7'd0, image_width_ff});
      hlim = $signed({7'd0, image_height_ff});
      if (fl < 0) fl = '0;
      if (ft < 0) ft = '0;
      if (cr > wlim) cr = wlim;
      if (cbt > hlim) cbt = hlim;
      if (cr < 0) cr = '0;
      if (cbt < 0) cbt = '0;
      ol = fl[12:0];
      ot = ft[12:0];
      orr = cr[12:0];
      ob = cbt[12:0];
   end

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      kept_in      = kept_ff;
      img_score_in = img_score_ff;
      rsp_data_in  = '0;
      if (accept && ins_go) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      case (cmd.op)
         CMD_NMS_START: kept_in = '0;
         CMD_SET_KEPT:  kept_in[cmd.idx_i] = cmd.keep;
         CMD_EMIT: begin
            if (ce.score > img_score_ff) img_score_in = ce.score;
            rsp_data_in.rect_left   = ol;
            rsp_data_in.rect_top    = ot;
            rsp_data_in.rect_right  = orr;
            rsp_data_in.rect_bottom = ob;
            rsp_data_in.det_score   = ce.score;
            rsp_data_in.det_class   = ce.cls;
            rsp_data_in.rect_empty  = (orr <= ol) || (ob <= ot);
         end
         CMD_SUMMARY: begin
            rsp_data_in.det_score     = img_score_ff;
            rsp_data_in.summary_flag  = 1'b1;
            rsp_data_in.overflow_flag = dropped_ff;
            rsp_data_in.last_item     = 1'b1;
            img_score_in = '0;
            count_in     = '0;
            dropped_in   = 1'b0;
            kept_in      = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_thr_ff     <= 16'd16384;
         ovl_thr_ff      <= 16'd29491;
         class_count_ff  <= 8'd80;
         image_width_ff  <= 13'd640;
         image_height_ff <= 13'd640;
         best_score_ff   <= '0;
         best_class_ff   <= '0;
         class_index_ff  <= '0;
         seen_ff         <= 1'b0;
         count_ff        <= '0;
         kept_ff         <= '0;
         dropped_ff      <= 1'b0;
         img_score_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CONF_THRESHOLD:    conf_thr_ff     <= csr_data;
               CSR_OVERLAP_THRESHOLD: ovl_thr_ff      <= csr_data;
               CSR_CLASS_COUNT:       class_count_ff  <= csr_data[7:0];
               CSR_IMAGE_WIDTH:       image_width_ff  <= csr_data[12:0];
               CSR_IMAGE_HEIGHT:      image_height_ff <= csr_data[12:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (anchor_end) begin
               best_score_ff  <= '0;
               best_class_ff  <= '0;
               class_index_ff <= '0;
               seen_ff        <= 1'b0;
            end else begin
               best_score_ff  <= best_score_in;
               best_class_ff  <= best_class_in;
               class_index_ff <= class_index_in;
               seen_ff        <= seen_in;
            end
         end
         count_ff     <= count_in;
         kept_ff      <= kept_in;
         dropped_ff   <= dropped_in;
         img_score_ff <= img_score_in;
         rsp_valid_ff <= (cmd.op == CMD_SUMMARY) ||
                         (cmd.op == CMD_EMIT && kept_ff[cmd.idx_i]);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && ins_go && !no_slot) begin
         for (int k = 0; k < MaxCandidates; k++) cand_ff[k] <= cand_in[k];
      end
      rsp_data_ff <= rsp_data_in;
      case (cmd.op)
         CMD_DIFF: begin
            dx_ff <= (x2 > x1) ? 18'(x2 - x1) : '0;
            dy_ff <= (y2 > y1) ? 18'(y2 - y1) : '0;
            wa_ff <= (ca.right > ca.left) ? 18'(ca.right - ca.left) : '0;
            ha_ff <= (ca.bottom > ca.top) ? 18'(ca.bottom - ca.top) : '0;
            wb_ff <= (cb.right > cb.left) ? 18'(cb.right - cb.left) : '0;
            hb_ff <= (cb.bottom > cb.top) ? 18'(cb.bottom - cb.top) : '0;
         end
         CMD_MINT:    inter_ff  <= dx_ff * dy_ff;
         CMD_MAREA_A: area_a_ff <= wa_ff * ha_ff;
         CMD_MAREA_B: area_b_ff <= wb_ff * hb_ff;
         CMD_UNION:   uni_ff    <= 37'(area_a_ff) + 37'(area_b_ff) - 37'(inter_ff);
         CMD_THR_LO:  plo_ff    <= ovl_thr_ff * uni_ff[15:0];
         CMD_THR_HI:  phi_ff    <= 37'(ovl_thr_ff) * 37'(uni_ff[36:16]);
         default: ;
      endcase
   end

   assign status.cand_count = count_ff;
   assign status.kept_j     = kept_ff[cmd.idx_j];
   assign status.class_eq   = (ca.cls == cb.cls);
   assign status.overlap    = (uni_ff != '0) && (lhs > rhs);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/ddn_controller.sv */
module ddn_controller
   import ddn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           last_anchor,
   input  ddn_status_type status,
   output ddn_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [3:0] {
      S_IDLE, S_NMS_I, S_NMS_J, S_DIFF, S_MINT, S_MA, S_MB, S_UNI,
      S_TLO, S_THI, S_CMP, S_EMIT, S_SUM
   } state_type;

   state_type           state_ff;
   logic [CandCntW-1:0] i_ff;
   logic [CandCntW-1:0] j_ff;
   logic                keep_ff;

   always_comb begin
      cmd.idx_i = i_ff[CandIdxW-1:0];
      cmd.idx_j = j_ff[CandIdxW-1:0];
      cmd.keep  = keep_ff;
      cmd.op    = CMD_NONE;
      unique case (state_ff)
         S_IDLE:  cmd.op = CMD_NONE;
         S_NMS_I: cmd.op = (i_ff == '0) ? CMD_NMS_START : CMD_NONE;
         S_NMS_J: cmd.op = (j_ff == i_ff || !keep_ff) ? CMD_SET_KEPT : CMD_NONE;
         S_DIFF:  cmd.op = CMD_DIFF;
         S_MINT:  cmd.op = CMD_MINT;
         S_MA:    cmd.op = CMD_MAREA_A;
         S_MB:    cmd.op = CMD_MAREA_B;
         S_UNI:   cmd.op = CMD_UNION;
         S_TLO:   cmd.op = CMD_THR_LO;
         S_THI:   cmd.op = CMD_THR_HI;
         S_CMP:   cmd.op = CMD_COMPARE;
         S_EMIT:  cmd.op = (i_ff == status.cand_count) ? CMD_NONE : CMD_EMIT;
         S_SUM:   cmd.op = CMD_SUMMARY;
         default: cmd.op = CMD_NONE;
      endcase
   end

   // kept mask is cleared on the first visit to S_NMS_I, so i is zero there
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         keep_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && last_anchor) begin
                  state_ff <= S_NMS_I;
                  i_ff     <= '0;
               end
            end
            S_NMS_I: begin
               if (i_ff == status.cand_count) begin
                  i_ff     <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  j_ff     <= '0;
                  keep_ff  <= 1'b1;
                  state_ff <= S_NMS_J;
               end
            end
            S_NMS_J: begin
               if (j_ff == i_ff || !keep_ff) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_NMS_I;
               end else if (status.kept_j && status.class_eq) begin
                  state_ff <= S_DIFF;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_DIFF: state_ff <= S_MINT;
            S_MINT: state_ff <= S_MA;
            S_MA:   state_ff <= S_MB;
            S_MB:   state_ff <= S_UNI;
            S_UNI:  state_ff <= S_TLO;
            S_TLO:  state_ff <= S_THI;
            S_THI:  state_ff <= S_CMP;
            S_CMP: begin
               if (status.overlap) keep_ff <= 1'b0;
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_NMS_J;
            end
            S_EMIT: begin
               if (i_ff == status.cand_count) begin
                  state_ff <= S_SUM;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_SUM: begin
               i_ff     <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/detection_decode_nms_unit.sv */
// channel   ports                                   transfer
// input     start, busy, req_data                   start high, busy low
// result    rsp_valid, rsp_data                     rsp_valid high, one cycle
// config    csr_write_enable, csr_index, csr_data   csr_write_enable high
//
// one class item per cycle while streaming and busy is low; argmax and sorted insert are registered on accept
// after last_anchor: suppression visits each candidate in turn and checks the earlier
// entries, running the overlap test on each same-class kept pair; then every entry is
// offered for emission, then the summary is sent; each result is registered
// synchronous reset restores the configuration registers and clears per-image state
// the receiver takes each result in its strobe cycle, nothing is held back
module detection_decode_nms_unit
   import ddn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   ddn_cmd_type    cmd;
   ddn_status_type status;
   logic           accept;

   assign accept = start && !busy;

   ddn_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .last_anchor (req_data.last_anchor),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   ddn_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule

/* tb/detection_decode_nms_unit_test.sv */
module detection_decode_nms_unit_test;
   import ddn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1000000;

   class nms_scoreboard;
      int unsigned conf_thr, ovl_thr, cls_cnt, img_w, img_h;
      int unsigned best_score, best_class, class_idx;
      bit          seen;
      int          c_l[MaxCandidates], c_t[MaxCandidates];
      int          c_r[MaxCandidates], c_b[MaxCandidates];
      int unsigned c_s[MaxCandidates], c_c[MaxCandidates];
      int unsigned c_n;
      bit          dropped_any;
      rsp_data_type pending[$];
      int errors, images, detections, overflows, suppressed, checked;

      function new();
         conf_thr = 16384;
         ovl_thr  = 29491;
         cls_cnt  = 80;
         img_w    = 640;
         img_h    = 640;
         clear_image();
      endfunction

      function void clear_image();
         best_score  = 0;
         best_class  = 0;
         class_idx   = 0;
         seen        = 0;
         c_n         = 0;
         dropped_any = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_CONF_THRESHOLD:    conf_thr = v;
            CSR_OVERLAP_THRESHOLD: ovl_thr  = v;
            CSR_CLASS_COUNT:       cls_cnt  = v[7:0];
            CSR_IMAGE_WIDTH:       img_w    = v[12:0];
            CSR_IMAGE_HEIGHT:      img_h    = v[12:0];
            default: ;
         endcase
      endfunction

      function longint span(int hi, int lo);
         return hi > lo ? longint'(hi) - longint'(lo) : 0;
      endfunction

      function bit boxes_overlap(int a, int b);
         int x1, y1, x2, y2;
         longint inter, uni;
         x1 = c_l[a] > c_l[b] ? c_l[a] : c_l[b];
         y1 = c_t[a] > c_t[b] ? c_t[a] : c_t[b];
         x2 = c_r[a] < c_r[b] ? c_r[a] : c_r[b];
         y2 = c_b[a] < c_b[b] ? c_b[a] : c_b[b];
         inter = span(x2, x1) * span(y2, y1);
         uni = span(c_r[a], c_l[a]) * span(c_b[a], c_t[a])
             + span(c_r[b], c_l[b]) * span(c_b[b], c_t[b]) - inter;
         if (uni <= 0) return 0;
         return inter * 64'd65536 > longint'(ovl_thr) * uni;
      endfunction

      function void insert_box(int l, int t, int r, int b, int unsigned s, int unsigned c);
         int unsigned p;
         p = 0;
         while (p < c_n && c_s[p] >= s) p++;
         if (c_n >= MaxCandidates) begin
            dropped_any = 1;
            if (p >= MaxCandidates) return;
            c_n = MaxCandidates - 1;
         end
         for (int k = c_n; k > p; k--) begin
            c_l[k] = c_l[k-1]; c_t[k] = c_t[k-1];
            c_r[k] = c_r[k-1]; c_b[k] = c_b[k-1];
            c_s[k] = c_s[k-1]; c_c[k] = c_c[k-1];
         end
         c_l[p] = l; c_t[p] = t; c_r[p] = r; c_b[p] = b;
         c_s[p] = s; c_c[p] = c;
         c_n++;
      endfunction

      function void note_input(req_data_type d);
         int cx, cy, w, h, l, t, r, b;
         int unsigned limit, img_score;
         bit [MaxCandidates-1:0] kept;
         bit keep;
         rsp_data_type o;
         cx = d.center_x;
         cy = d.center_y;
         w  = int'(d.box_width);
         h  = int'(d.box_height);
         limit = cls_cnt < MaxClasses ? cls_cnt : MaxClasses;
         if (class_idx < limit && (!seen || d.class_score > best_score)) begin
            best_score = d.class_score;
            best_class = class_idx;
            seen = 1;
         end
         if (class_idx < MaxClasses) class_idx++;
         if (d.last_class || d.last_anchor) begin
            if (seen && best_score >= conf_thr)
               insert_box(2*cx - w, 2*cy - h, 2*cx + w, 2*cy + h, best_score, best_class);
            best_score = 0;
            best_class = 0;
            class_idx  = 0;
            seen       = 0;
         end
         if (!d.last_anchor) return;
         kept = '0;
         for (int i = 0; i < c_n; i++) begin
            keep = 1;
            for (int j = 0; j < i && keep; j++)
               if (kept[j] && c_c[j] == c_c[i] && boxes_overlap(j, i)) keep = 0;
            kept[i] = keep;
            if (!keep) suppressed++;
         end
         img_score = 0;
         for (int i = 0; i < c_n; i++) begin
            if (!kept[i]) continue;
            if (c_s[i] > img_score) img_score = c_s[i];
            l = c_l[i] >>> 5;
            t = c_t[i] >>> 5;
            r = -((-c_r[i]) >>> 5);
            b = -((-c_b[i]) >>> 5);
            if (l < 0) l = 0;
            if (t < 0) t = 0;
            if (r > int'(img_w)) r = img_w;
            if (b > int'(img_h)) b = img_h;
            if (r < 0) r = 0;
            if (b < 0) b = 0;
            o = '0;
            o.rect_left   = l[12:0];
            o.rect_top    = t[12:0];
            o.rect_right  = r[12:0];
            o.rect_bottom = b[12:0];
            o.det_score   = c_s[i][15:0];
            o.det_class   = c_c[i][6:0];
            o.rect_empty  = (r <= l || b <= t);
            pending = {pending, o};
            detections++;
         end
         o = '0;
         o.det_score     = img_score[15:0];
         o.summary_flag  = 1;
         o.overflow_flag = dropped_any;
         o.last_item     = 1;
         pending = {pending, o};
         if (dropped_any) overflows++;
         images++;
         clear_image();
      endfunction

      function void compare_field(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_data_type a);
         rsp_data_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         compare_field("rect_left", e.rect_left, a.rect_left);
         compare_field("rect_top", e.rect_top, a.rect_top);
         compare_field("rect_right", e.rect_right, a.rect_right);
         compare_field("rect_bottom", e.rect_bottom, a.rect_bottom);
         compare_field("det_score", e.det_score, a.det_score);
         compare_field("det_class", e.det_class, a.det_class);
         compare_field("rect_empty", e.rect_empty, a.rect_empty);
         compare_field("summary_flag", e.summary_flag, a.summary_flag);
         compare_field("overflow_flag", e.overflow_flag, a.overflow_flag);
         compare_field("last_item", e.last_item, a.last_item);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_data_type req_data;
   logic         rsp_valid;
   rsp_data_type rsp_data;
   logic         csr_write_enable;
   logic [2:0]   csr_index;
   logic [15:0]  csr_data;

   nms_scoreboard sb = new();
   int  cycles;
   int  idle_pct;
   int  items_sent;

   detection_decode_nms_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.set_register(csr_index, csr_data);
         if (start && !busy) sb.note_input(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // start stays high between back-to-back transfers
   task automatic send_item(req_data_type d);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every expected result has come, then let the block settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic configure(int unsigned conf, int unsigned ovl, int unsigned cls,
                            int unsigned wid, int unsigned hgt);
      logic [15:0] vals [5];
      vals = '{conf[15:0], ovl[15:0], cls[15:0], wid[15:0], hgt[15:0]};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= 3'(i);
         csr_data         <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_data_type mk(int cx, int cy, int w, int h, int s, bit lc, bit la);
      req_data_type d;
      d.center_x    = 16'(cx);
      d.center_y    = 16'(cy);
      d.box_width   = 16'(w);
      d.box_height  = 16'(h);
      d.class_score = 16'(s);
      d.last_class  = lc;
      d.last_anchor = la;
      return d;
   endfunction

   // well-formed image with random content; a share of anchors, set by spread_pct, span the full field range
   task automatic send_image(int anchors, int min_k, int max_k, int spread_pct);
      req_data_type d;
      int k, s;
      for (int a = 0; a < anchors; a++) begin
         k = $urandom_range(min_k, max_k);
         if ($urandom_range(99) < spread_pct) begin
            d.center_x   = 16'($urandom);
            d.center_y   = 16'($urandom);
            d.box_width  = 16'($urandom);
            d.box_height = 16'($urandom);
         end else begin
            d.center_x   = 16'($urandom_range(1600, 4800));
            d.center_y   = 16'($urandom_range(1600, 4800));
            d.box_width  = 16'($urandom_range(0, 1600));
            d.box_height = 16'($urandom_range(0, 1600));
         end
         s = $urandom_range(0, 65535);
         for (int c = 0; c < k; c++) begin
            case ($urandom_range(0, 7))
               0: s = 0;
               1: s = 65535;
               2: ;
               default: s = $urandom_range(0, 65535);
            endcase
            d.class_score = 16'(s);
            if ($urandom_range(0, 5) == 0) d.box_width = 16'($urandom_range(0, 2000));
            d.last_class  = (c == k - 1);
            d.last_anchor = (a == anchors - 1) && (c == k - 1);
            if (d.last_anchor && $urandom_range(0, 3) == 0) d.last_class = 1'b0;
            send_item(d);
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      cycles           <= 0;
      idle_pct   = 0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: tie keeps the first class, score exactly at threshold,
      // just below it, same-class overlap, last anchor without last class
      send_item(mk(3200, 3200, 800, 800, 40000, 0, 0));
      send_item(mk(3200, 3200, 800, 800, 40000, 0, 0));
      send_item(mk(3200, 3200, 800, 800, 100, 1, 0));
      send_item(mk(-32768, -32768, 65535, 65535, 16384, 1, 0));
      send_item(mk(100, 100, 50, 50, 16383, 1, 0));
      send_item(mk(3210, 3190, 800, 800, 30000, 1, 0));
      send_item(mk(32767, 32767, 65535, 65535, 65535, 0, 1));
      // empty image
      send_item(mk(0, 0, 0, 0, 0, 1, 1));
      // degenerate boxes of one class are never suppressed
      send_item(mk(500, 500, 0, 0, 65535, 1, 0));
      send_item(mk(500, 500, 0, 0, 65535, 1, 1));
      drain();
      configure(16384, 29491, 2, 0, 4096);
      // zero width clip, third class beyond the class count does not compete
      send_item(mk(1000, 1000, 300, 300, 20000, 0, 0));
      send_item(mk(1000, 1000, 300, 300, 30000, 0, 0));
      send_item(mk(1000, 1000, 300, 300, 65535, 1, 0));
      send_item(mk(-1, 5, 1, 65535, 50000, 1, 1));
      drain();
      configure(0, 65535, 0, 640, 640);
      send_item(mk(800, 800, 100, 100, 65535, 1, 0));
      send_item(mk(800, 800, 100, 100, 65535, 1, 1));
      drain();

      // overflow of the candidate store and hard suppression
      idle_pct = 38;
      configure(0, 0, 1, 4096, 4096);
      send_image(36, 1, 1, 10);
      for (int n = 0; n < 6; n++) send_image($urandom_range(3, 9), 1, 2, 15);
      drain();

      // saturating class index, strict threshold, one-pixel height
      idle_pct = 49;
      configure(65535, 65535, 200, 8191, 1);
      send_image(1, 130, 130, 0);
      drain();
      for (int n = 0; n < 6; n++) begin
         send_image($urandom_range(2, 5), 1, 3, 25);
         if (n == 2) drain();
      end
      drain();

      idle_pct = 0;
      configure($urandom_range(8000, 40000), $urandom_range(0, 65535), $urandom_range(2, 6),
                $urandom_range(1, 4096), $urandom_range(1, 4096));
      for (int n = 0; n < 4; n++) send_image($urandom_range(2, 6), 1, 5, 12);
      drain();

      $display("%0d items in %0d images, %0d results checked", items_sent, sb.images,
               sb.checked);
      $display("%0d detections, %0d suppressed, %0d images overflowed", sb.detections,
               sb.suppressed, sb.overflows);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
